@@ rtl/core/dtq_pkg.sv @@
// Shared definitions for the delta timer queue: sizes, command and result
// codes, and the sequencer state type. Depends on nothing.
package dtq_pkg;

  localparam int NUM_SLOTS    = 16;
  localparam int MAX_EXPIRIES = 63;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int EXP_W = $clog2(MAX_EXPIRIES + 1);
  localparam int REM_W = 34;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  localparam logic [31:0] INF_DELAY = 32'hFFFF_FFFF;

  // Most negative remaining time; lateness saturates here.
  localparam logic signed [REM_W-1:0] REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EVAL,
    ST_FIRE,
    ST_UPD,
    ST_DONE
  } state_e;

endpackage

@@ rtl/core/delta_timer_queue.sv @@
// Top level of the delta timer queue: slot memories, sweep sequencer and
// output register. Depends on dtq_pkg.
//
// Usage: one input channel carries commands (tick, set, cancel) and one
// output channel carries results. Every command produces a single done
// transfer (kind 1, last 1) holding the delay to the next expiry; a tick
// first produces one expiry transfer per due slot, in order of remaining
// time with ties to the lower slot index, at most MAX_EXPIRIES per tick.
// Beyond that limit the done transfer carries overflow and the pending
// expiries are reported by the next tick.
// Remaining times and reload intervals live in two synchronous RAMs with a
// registered read; armed bits live in flip-flops. Every command runs a sweep
// over all NUM_SLOTS entries that finds the earliest armed slot, and a tick
// also subtracts the elapsed time on that pass. Each expiry adds a reload
// read-modify-write and one more sweep. Commands are taken one at a time;
// the next command is accepted while the previous done transfer still waits
// in the output register. A stalled receiver holds the sequencer before it
// loads the next result.
// Reset clears all armed bits and the control state; the RAMs are not
// cleared, since an entry is only read while its slot is armed.
module delta_timer_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] delay_i,
  input  logic [31:0] interval_i,
  input  logic [31:0] elapsed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [3:0]  expired_slot_o,
  output logic [31:0] next_delay_o,
  output logic        overflow_o,
  output logic        last_o
);

  localparam int NS    = dtq_pkg::NUM_SLOTS;
  localparam int IDX_W = dtq_pkg::IDX_W;
  localparam int CNT_W = dtq_pkg::CNT_W;
  localparam int EXP_W = dtq_pkg::EXP_W;
  localparam int REM_W = dtq_pkg::REM_W;

  dtq_pkg::state_e state_q, state_d;

  // Slot storage.
  logic signed [REM_W-1:0] rem_mem [NS];
  logic        [31:0]      rld_mem [NS];
  logic signed [REM_W-1:0] rem_rd_q;
  logic        [31:0]      rld_rd_q;
  logic [IDX_W-1:0]        mem_raddr;
  logic                    rem_we, rld_we;
  logic [IDX_W-1:0]        rem_waddr;
  logic signed [REM_W-1:0] rem_wdata;
  logic [NS-1:0]           armed_q, armed_d;

  // Sweep control.
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]  rd_idx_q;
  logic              sub_q, sub_d;
  logic              tick_q, tick_d;
  logic [31:0]       elapsed_q, elapsed_d;

  // Earliest armed slot found by the current sweep.
  logic                    best_vld_q, best_vld_d;
  logic signed [REM_W-1:0] best_val_q, best_val_d;
  logic [IDX_W-1:0]        best_idx_q, best_idx_d;

  logic [EXP_W-1:0] exp_cnt_q, exp_cnt_d;
  logic             ovf_q, ovf_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic        out_free, out_load;
  logic        kind_q, kind_d;
  logic [3:0]  oslot_q, oslot_d;
  logic [31:0] nd_q, nd_d;
  logic        oovf_q, oovf_d;
  logic        last_q, last_d;

  logic              in_acc;
  logic              slot_ok;
  logic              use_entry;
  logic              best_pos;
  logic signed [REM_W:0]   diff;
  logic signed [REM_W-1:0] sub_val, cur_val;
  logic [31:0]       nd_val;

  assign in_ready_o = (state_q == dtq_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign slot_ok    = (32'(slot_i) < 32'(NS));
  assign best_pos   = best_val_q > REM_W'(signed'(0));

  // Saturating subtract of the elapsed time from the entry read last cycle.
  assign diff    = {rem_rd_q[REM_W-1], rem_rd_q} - (REM_W+1)'({1'b0, elapsed_q});
  assign sub_val = (diff[REM_W] != diff[REM_W-1]) ? dtq_pkg::REM_MIN : diff[REM_W-1:0];
  assign cur_val = sub_q ? sub_val : rem_rd_q;
  assign use_entry = rd_vld_q && armed_q[rd_idx_q];

  // Delay to the next expiry, saturated to 32 bits; zero on overflow or when none lies ahead.
  always_comb begin
    if (ovf_q || !best_vld_q || !best_pos) begin
      nd_val = '0;
    end else if (best_val_q > REM_W'(signed'(33'h0_FFFF_FFFF))) begin
      nd_val = 32'hFFFF_FFFF;
    end else begin
      nd_val = best_val_q[31:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtq_pkg::ST_IDLE: begin
        if (in_acc) state_d = dtq_pkg::ST_SWEEP;
      end
      dtq_pkg::ST_SWEEP: begin
        if (idx_q == CNT_W'(NS)) state_d = dtq_pkg::ST_EVAL;
      end
      dtq_pkg::ST_EVAL: begin
        priority if (!tick_q || !best_vld_q || best_pos) begin
          state_d = dtq_pkg::ST_DONE;
        end else if (exp_cnt_q == EXP_W'(dtq_pkg::MAX_EXPIRIES)) begin
          state_d = dtq_pkg::ST_DONE;
        end else begin
          state_d = dtq_pkg::ST_FIRE;
        end
      end
      dtq_pkg::ST_FIRE: begin
        if (out_free) state_d = dtq_pkg::ST_UPD;
      end
      dtq_pkg::ST_UPD: begin
        state_d = dtq_pkg::ST_SWEEP;
      end
      dtq_pkg::ST_DONE: begin
        if (out_free) state_d = dtq_pkg::ST_IDLE;
      end
      default: state_d = dtq_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    armed_d    = armed_q;
    idx_d      = idx_q;
    rd_vld_d   = 1'b0;
    sub_d      = sub_q;
    tick_d     = tick_q;
    elapsed_d  = elapsed_q;
    best_vld_d = best_vld_q;
    best_val_d = best_val_q;
    best_idx_d = best_idx_q;
    exp_cnt_d  = exp_cnt_q;
    ovf_d      = ovf_q;
    rem_we     = 1'b0;
    rld_we     = 1'b0;
    rem_waddr  = rd_idx_q;
    rem_wdata  = sub_val;
    mem_raddr  = idx_q[IDX_W-1:0];
    out_load   = 1'b0;
    kind_d     = kind_q;
    oslot_d    = oslot_q;
    nd_d       = nd_q;
    oovf_d     = oovf_q;
    last_d     = last_q;

    unique case (state_q)
      dtq_pkg::ST_IDLE: begin
        rem_waddr = IDX_W'(slot_i);
        rem_wdata = REM_W'({2'b00, delay_i});
        if (in_acc) begin
          tick_d     = (cmd_i == dtq_pkg::CMD_TICK);
          sub_d      = (cmd_i == dtq_pkg::CMD_TICK);
          elapsed_d  = elapsed_i;
          exp_cnt_d  = '0;
          ovf_d      = 1'b0;
          idx_d      = '0;
          best_vld_d = 1'b0;
          if (slot_ok && cmd_i == dtq_pkg::CMD_SET) begin
            if (delay_i == dtq_pkg::INF_DELAY) begin
              armed_d[IDX_W'(slot_i)] = 1'b0;
            end else begin
              armed_d[IDX_W'(slot_i)] = 1'b1;
              rem_we = 1'b1;
              rld_we = 1'b1;
            end
          end else if (slot_ok && cmd_i == dtq_pkg::CMD_CANCEL) begin
            armed_d[IDX_W'(slot_i)] = 1'b0;
          end
        end
      end
      dtq_pkg::ST_SWEEP: begin
        if (idx_q < CNT_W'(NS)) begin
          rd_vld_d = 1'b1;
          idx_d    = idx_q + CNT_W'(1);
        end
        if (use_entry) begin
          rem_we = sub_q;
          if (!best_vld_q || cur_val < best_val_q) begin
            best_vld_d = 1'b1;
            best_val_d = cur_val;
            best_idx_d = rd_idx_q;
          end
        end
      end
      dtq_pkg::ST_EVAL: begin
        sub_d = 1'b0;
        if (tick_q && best_vld_q && !best_pos &&
            exp_cnt_q == EXP_W'(dtq_pkg::MAX_EXPIRIES)) begin
          ovf_d = 1'b1;
        end
      end
      dtq_pkg::ST_FIRE: begin
        mem_raddr = best_idx_q;
        if (out_free) begin
          out_load  = 1'b1;
          kind_d    = dtq_pkg::KIND_EXPIRY;
          oslot_d   = 4'(best_idx_q);
          nd_d      = '0;
          oovf_d    = 1'b0;
          last_d    = 1'b0;
          exp_cnt_d = exp_cnt_q + EXP_W'(1);
        end
      end
      dtq_pkg::ST_UPD: begin
        // A one-shot slot is disarmed, a periodic one reloads and may fire
        // again on the following sweep.
        rem_waddr  = best_idx_q;
        rem_wdata  = best_val_q + REM_W'({2'b00, rld_rd_q});
        if (rld_rd_q == '0) begin
          armed_d[best_idx_q] = 1'b0;
        end else begin
          rem_we = 1'b1;
        end
        idx_d      = '0;
        best_vld_d = 1'b0;
      end
      dtq_pkg::ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = dtq_pkg::KIND_DONE;
          oslot_d  = '0;
          nd_d     = nd_val;
          oovf_d   = ovf_q;
          last_d   = 1'b1;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Slot memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (rem_we) rem_mem[rem_waddr] <= rem_wdata;
    rem_rd_q <= rem_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rld_we) rld_mem[IDX_W'(slot_i)] <= interval_i;
    rld_rd_q <= rld_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtq_pkg::ST_IDLE;
      armed_q     <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      sub_q       <= 1'b0;
      tick_q      <= 1'b0;
      best_vld_q  <= 1'b0;
      exp_cnt_q   <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      idx_q       <= idx_d;
      rd_vld_q    <= rd_vld_d;
      sub_q       <= sub_d;
      tick_q      <= tick_d;
      best_vld_q  <= best_vld_d;
      exp_cnt_q   <= exp_cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= idx_q[IDX_W-1:0];
    elapsed_q  <= elapsed_d;
    best_val_q <= best_val_d;
    best_idx_q <= best_idx_d;
    kind_q     <= kind_d;
    oslot_q    <= oslot_d;
    nd_q       <= nd_d;
    oovf_q     <= oovf_d;
    last_q     <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign expired_slot_o = oslot_q;
  assign next_delay_o   = nd_q;
  assign overflow_o     = oovf_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  // The per-tick expiry count never passes the limit.
  a_exp_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_cnt_q <= EXP_W'(dtq_pkg::MAX_EXPIRIES))
    else $error("expiry count above limit");

  // The reload write-back always follows the reload read of the fired slot.
  a_upd_after_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dtq_pkg::ST_UPD |-> $past(state_q) == dtq_pkg::ST_FIRE)
    else $error("reload update without a preceding fire");

  // An overflow is only reported in a final done transfer with no delay.
  a_ovf_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> last_o && kind_o == dtq_pkg::KIND_DONE &&
    next_delay_o == '0)
    else $error("overflow on a non-final result");
`endif

endmodule

@@ tb/dtq_result_checker.sv @@
// Result checker for the delta timer queue: watches both channels, keeps its
// own model of the timer bank and compares every result. Depends on dtq_pkg.
module dtq_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] delay_i,
  input  logic [31:0] interval_i,
  input  logic [31:0] elapsed_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        kind_i,
  input  logic [3:0]  expired_slot_i,
  input  logic [31:0] next_delay_i,
  input  logic        overflow_i,
  input  logic        last_i,
  output int unsigned outstanding_o,
  output int unsigned mismatches_o
);

  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [31:0] next_delay;
    logic        overflow;
    logic        last;
  } timer_result_t;

  localparam longint LATE_FLOOR = dtq_pkg::REM_MIN;
  localparam longint DELAY_CEIL = 64'd4294967295;

  bit            slot_armed [dtq_pkg::NUM_SLOTS];
  longint        time_left  [dtq_pkg::NUM_SLOTS];
  logic [31:0]   reload_ms  [dtq_pkg::NUM_SLOTS];
  timer_result_t timer_results_due [$];

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] seen);
    mismatches_o++;
    $display("[%0t] timer queue mismatch: %s expected %0h got %0h",
             $time, what, want, seen);
  endtask

  // Armed slot with the least remaining time, lowest index on ties; -1 if none.
  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < dtq_pkg::NUM_SLOTS; i++) begin
      if (slot_armed[i] && (best < 0 || time_left[i] < time_left[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  task automatic predict_command(input logic [1:0] cmd, input logic [3:0] slot,
                                 input logic [31:0] delay, input logic [31:0] interval,
                                 input logic [31:0] elapsed);
    int            fired;
    int            best;
    bit            deferred;
    longint        step;
    timer_result_t res;
    fired    = 0;
    deferred = 1'b0;
    step     = {32'd0, elapsed};
    case (cmd)
      dtq_pkg::CMD_TICK: begin
        for (int i = 0; i < dtq_pkg::NUM_SLOTS; i++) begin
          if (slot_armed[i]) begin
            time_left[i] = (time_left[i] - step < LATE_FLOOR) ? LATE_FLOOR
                                                              : time_left[i] - step;
          end
        end
        best = earliest_slot();
        while (best >= 0 && time_left[best] <= 0) begin
          // Past the per-tick limit the rest stay due for the next tick.
          if (fired >= dtq_pkg::MAX_EXPIRIES) begin
            deferred = 1'b1;
            break;
          end
          res      = '0;
          res.kind = dtq_pkg::KIND_EXPIRY;
          res.slot = 4'(best);
          timer_results_due.push_back(res);
          fired++;
          if (reload_ms[best] == 32'd0) begin
            slot_armed[best] = 1'b0;
          end else begin
            time_left[best] += {32'd0, reload_ms[best]};
          end
          best = earliest_slot();
        end
      end
      dtq_pkg::CMD_SET: begin
        if (slot < dtq_pkg::NUM_SLOTS) begin
          if (delay == dtq_pkg::INF_DELAY) begin
            slot_armed[slot] = 1'b0;
          end else begin
            slot_armed[slot] = 1'b1;
            time_left[slot]  = {32'd0, delay};
            reload_ms[slot]  = interval;
          end
        end
      end
      dtq_pkg::CMD_CANCEL: begin
        if (slot < dtq_pkg::NUM_SLOTS) slot_armed[slot] = 1'b0;
      end
      default: ;
    endcase

    res          = '0;
    res.kind     = dtq_pkg::KIND_DONE;
    res.last     = 1'b1;
    res.overflow = deferred;
    if (!deferred) begin
      best = earliest_slot();
      if (best >= 0 && time_left[best] > 0) begin
        res.next_delay = (time_left[best] > DELAY_CEIL) ? 32'hFFFF_FFFF
                                                        : 32'(time_left[best]);
      end
    end
    timer_results_due.push_back(res);
  endtask

  task automatic check_result();
    timer_result_t want;
    if (timer_results_due.size() == 0) begin
      report_mismatch("result with nothing due, slot", 32'd0, {28'd0, expired_slot_i});
      return;
    end
    want = timer_results_due.pop_front();
    if (kind_i !== want.kind) report_mismatch("kind", 32'(want.kind), 32'(kind_i));
    if (expired_slot_i !== want.slot) begin
      report_mismatch("expired_slot", 32'(want.slot), 32'(expired_slot_i));
    end
    if (next_delay_i !== want.next_delay) begin
      report_mismatch("next_delay", want.next_delay, next_delay_i);
    end
    if (overflow_i !== want.overflow) begin
      report_mismatch("overflow", 32'(want.overflow), 32'(overflow_i));
    end
    if (last_i !== want.last) report_mismatch("last", 32'(want.last), 32'(last_i));
  endtask

  // Output transfers are checked before the same edge's input transfer is
  // predicted, since a fresh command cannot have a result out yet.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dtq_pkg::NUM_SLOTS; i++) begin
        slot_armed[i] = 1'b0;
        time_left[i]  = 0;
        reload_ms[i]  = 32'd0;
      end
      timer_results_due.delete();
      outstanding_o = 0;
      mismatches_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) begin
        predict_command(cmd_i, slot_i, delay_i, interval_i, elapsed_i);
      end
      outstanding_o = timer_results_due.size();
    end
  end

endmodule

@@ tb/tb_delta_timer_queue.sv @@
// Testbench top for the delta timer queue: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on dtq_pkg,
// delta_timer_queue and dtq_result_checker.
module tb_delta_timer_queue;

  // The block treats the fourth command code as a no-op that only reports done.
  localparam logic [1:0]  CMD_NONE     = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 290;
  // Worst case per command is 64 results, each with a full sweep plus a full
  // receiver stall; the limit covers that several times.
  localparam int unsigned CYCLE_LIMIT  = 2_500_000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned MAX_GAP      = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = dtq_pkg::CMD_TICK;
  logic [3:0]  slot_i = 4'd0;
  logic [31:0] delay_i = 32'd0;
  logic [31:0] interval_i = 32'd0;
  logic [31:0] elapsed_i = 32'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [3:0]  expired_slot_o;
  logic [31:0] next_delay_o;
  logic        overflow_o;
  logic        last_o;

  int unsigned results_outstanding;
  int unsigned mismatches;

  // While calm is set neither side inserts idle cycles, so the block also
  // sees stretches of back-to-back traffic.
  bit          calm = 1'b0;
  bit          out_hold = 1'b0;
  int unsigned holds_wanted = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  delta_timer_queue dut (.*);

  dtq_result_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .cmd_i          (cmd_i),
    .slot_i         (slot_i),
    .delay_i        (delay_i),
    .interval_i     (interval_i),
    .elapsed_i      (elapsed_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_i         (kind_o),
    .expired_slot_i (expired_slot_o),
    .next_delay_i   (next_delay_o),
    .overflow_i     (overflow_o),
    .last_i         (last_o),
    .outstanding_o  (results_outstanding),
    .mismatches_o   (mismatches)
  );

  // Offers one command after a random number of idle cycles and returns at
  // the rising edge where the transfer happens. Inputs only move at falling
  // edges, and each falling edge sees at most one update of in_valid_i, so
  // back-to-back commands keep valid high without a glitch.
  task automatic send_cmd(input logic [1:0] cmd, input logic [3:0] slot,
                          input logic [31:0] delay, input logic [31:0] interval,
                          input logic [31:0] elapsed);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    slot_i     <= slot;
    delay_i    <= delay;
    interval_i <= interval;
    elapsed_i  <= elapsed;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Random traffic: mostly arming and ticking with small times so that
  // slots really expire, with a share of full-range values, infinite delays,
  // very short periods that run into the per-tick limit, cancels and no-ops.
  task automatic send_random_command();
    int unsigned roll;
    logic [31:0] dly;
    logic [31:0] ivl;
    logic [31:0] el;
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       dly = dtq_pkg::INF_DELAY;
      1, 2:    dly = $urandom();
      default: dly = $urandom_range(0, 300);
    endcase
    case ($urandom_range(0, 19))
      0:                   ivl = $urandom_range(1, 4);
      1, 2:                ivl = $urandom();
      3, 4, 5, 6, 7, 8, 9: ivl = $urandom_range(5, 200);
      default:             ivl = 32'd0;
    endcase
    case ($urandom_range(0, 19))
      0, 1:    el = $urandom();
      2, 3:    el = 32'd0;
      default: el = $urandom_range(0, 120);
    endcase
    if (roll < 38) begin
      send_cmd(dtq_pkg::CMD_SET, 4'($urandom()), dly, ivl, $urandom());
    end else if (roll < 54) begin
      send_cmd(dtq_pkg::CMD_CANCEL, 4'($urandom()), $urandom(), $urandom(), $urandom());
    end else if (roll < 96) begin
      send_cmd(dtq_pkg::CMD_TICK, 4'($urandom()), $urandom(), $urandom(), el);
    end else begin
      send_cmd(CMD_NONE, 4'($urandom()), $urandom(), $urandom(), $urandom());
    end
  endtask

  // Receiver: after each result transfer it waits a random number of cycles
  // before taking the next one. A long hold from the pressure process below
  // overrides that and keeps ready low.
  initial begin
    int unsigned wait_left;
    wait_left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (out_hold || wait_left > 0) begin
        out_ready_i <= 1'b0;
        if (!out_hold) wait_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) wait_left = calm ? 0 : $urandom_range(0, MAX_GAP);
    end
  end

  // Pressure: on request the receiver stalls for a long stretch while the
  // sender keeps offering, so the output register fills and the block has to
  // stall its input.
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (holds_done < holds_wanted) begin
        out_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_hold = 1'b0;
        holds_done++;
      end
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. An empty bank reports zero delay, and the unused command
    // code only reports done.
    send_cmd(dtq_pkg::CMD_TICK, 4'd0, 32'd0, 32'd0, 32'd0);
    send_cmd(CMD_NONE, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Zero delay one-shot, and the largest finite delay with an all-ones period.
    send_cmd(dtq_pkg::CMD_SET, 4'd0, 32'd0, 32'd0, 32'd0);
    send_cmd(dtq_pkg::CMD_SET, 4'd15, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0);
    // An infinite delay disarms a slot that was armed.
    send_cmd(dtq_pkg::CMD_SET, 4'd7, 32'd5, 32'd0, 32'd0);
    send_cmd(dtq_pkg::CMD_SET, 4'd7, dtq_pkg::INF_DELAY, 32'd9, 32'd0);
    send_cmd(dtq_pkg::CMD_TICK, 4'd0, 32'd0, 32'd0, 32'd0);
    send_cmd(dtq_pkg::CMD_CANCEL, 4'd15, 32'd0, 32'd0, 32'd0);
    // Tie between a periodic and a one-shot slot: the lower index goes first,
    // and the periodic one fires again within the same tick.
    send_cmd(dtq_pkg::CMD_SET, 4'd3, 32'd10, 32'd4, 32'd0);
    send_cmd(dtq_pkg::CMD_SET, 4'd4, 32'd10, 32'd0, 32'd0);
    send_cmd(dtq_pkg::CMD_TICK, 4'd0, 32'd0, 32'd0, 32'd20);
    // A one-ms period behind by the largest elapsed time hits the per-tick
    // limit and sets overflow; repeated ticks drive the lateness into
    // saturation.
    send_cmd(dtq_pkg::CMD_SET, 4'd1, 32'd0, 32'd1, 32'd0);
    send_cmd(dtq_pkg::CMD_TICK, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_cmd(dtq_pkg::CMD_TICK, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_cmd(dtq_pkg::CMD_TICK, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_cmd(dtq_pkg::CMD_TICK, 4'd0, 32'd0, 32'd0, 32'd0);
    send_cmd(dtq_pkg::CMD_CANCEL, 4'd1, 32'd0, 32'd0, 32'd0);
    send_cmd(dtq_pkg::CMD_CANCEL, 4'd3, 32'd0, 32'd0, 32'd0);
    send_cmd(dtq_pkg::CMD_SET, 4'd9, 32'h8000_0001, 32'h7FFF_FFFF, 32'd0);
    send_cmd(dtq_pkg::CMD_TICK, 4'd5, 32'd0, 32'd0, 32'h0000_0001);

    // Random part, with two long receiver stalls and calm stretches.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = ((n / 35) % 4) == 2;
      if (n == 0 || n == 150) holds_wanted++;
      send_random_command();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    calm = 1'b1;
    wait (results_outstanding == 0);
    // Give a stray extra result time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ delta_timer_queue.f @@
rtl/core/dtq_pkg.sv
rtl/core/delta_timer_queue.sv
tb/dtq_result_checker.sv
tb/tb_delta_timer_queue.sv
